// File: src/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int MAX_BORDER  = 15;
    localparam int PIXEL_BITS  = 24;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 8;
    localparam int BORDER_W    = 4;
    localparam int CFG_DATA_W  = 8;

    localparam int CMD_DEPTH   = 4;
    localparam int CMD_AW      = $clog2(CMD_DEPTH);
    localparam int CMD_CW      = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_HEIGHT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_BORDER = 2'd2,
        CFG_MODE   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RANGE      = 2'd1,
        ST_BORDER     = 2'd2,
        ST_INCOMPLETE = 2'd3
    } status_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef struct packed {
        logic [0:0]  operation;
        logic [23:0] pixel;
        logic [7:0]  row;
        logic [7:0]  col;
    } in_item_t;

    typedef struct packed {
        logic [23:0] padded_pixel;
        status_t     status;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]    height;
        logic [DIM_W-1:0]    width;
        logic [BORDER_W-1:0] border;
        logic                mode;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                  is_fetch;
        logic [PIXEL_BITS-1:0] pixel;
        logic [ADDR_W-1:0]     load_addr;
        logic [ROW_W-1:0]      r;
        logic [COL_W-1:0]      c;
        status_t               status;
    } cmd_t;

endpackage

`default_nettype wire

// File: src/mbe_front.sv
`default_nettype none

module mbe_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire mbe_pkg::in_item_t             request,
    output logic                               full,
    input  wire logic                          cfg_we,
    input  wire mbe_pkg::cfg_index_t           cfg_index,
    input  wire logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
    output mbe_pkg::cfg_t                      cfg,
    output logic                               cmd_valid,
    output mbe_pkg::cmd_t                      cmd_item,
    input  wire logic                          cmd_full
);

    mbe_pkg::cfg_t                    cfg_reg, cfg_next;
    logic [mbe_pkg::ADDR_W-1:0]       load_pos_reg, load_pos_next;
    logic [mbe_pkg::COL_W-1:0]        load_col_reg, load_col_next;
    logic [mbe_pkg::ROW_W-1:0]        load_row_reg, load_row_next;
    logic                             frame_complete_reg, frame_complete_next;
    logic                             front_valid_reg, front_valid_next;
    mbe_pkg::cmd_t                    front_item_reg, front_item_next;
    logic                             accept;
    logic                             geom_write;
    logic [mbe_pkg::DIM_W-1:0]        clamped_dim, dim_max;
    logic [mbe_pkg::DIM_W:0]          row_limit, col_limit;
    logic                             out_of_range, too_wide;
    logic [mbe_pkg::DIM_W-1:0]        fetch_row_idx, fetch_col_idx;

    // reflect a padded coordinate back into 0..size-1
    function automatic logic [mbe_pkg::DIM_W-1:0] mirror_index(
        input logic [7:0]                   padded,
        input logic [mbe_pkg::BORDER_W-1:0] bord,
        input logic [mbe_pkg::DIM_W-1:0]    size,
        input logic                         mode
    );
        logic signed [10:0] s;
        logic signed [10:0] n;
        s = $signed({3'b000, padded}) - $signed({7'b0000000, bord});
        n = $signed({3'b000, size});
        if (s < 0)
            s = mode ? (-s - 11'sd1) : -s;
        else if (s >= n)
            s = mode ? (n + n - 11'sd1 - s) : (n + n - 11'sd2 - s);
        if (s < 0)
            s = 11'sd0;
        if (s >= n)
            s = n - 11'sd1;
        return s[mbe_pkg::DIM_W-1:0];
    endfunction

    assign full      = front_valid_reg && cmd_full;
    assign accept    = push && !full;
    assign cfg       = cfg_reg;
    assign cmd_valid = front_valid_reg;
    assign cmd_item  = front_item_reg;

    assign geom_write = cfg_we && (cfg_index == mbe_pkg::CFG_HEIGHT ||
                                   cfg_index == mbe_pkg::CFG_WIDTH);

    always_comb
    begin
        dim_max = (cfg_index == mbe_pkg::CFG_WIDTH) ? mbe_pkg::DIM_W'(mbe_pkg::MAX_WIDTH)
                                                    : mbe_pkg::DIM_W'(mbe_pkg::MAX_HEIGHT);
        if (cfg_data == '0)
            clamped_dim = mbe_pkg::DIM_W'(1);
        else if (cfg_data > dim_max)
            clamped_dim = dim_max;
        else
            clamped_dim = cfg_data;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mbe_pkg::CFG_HEIGHT: cfg_next.height = clamped_dim;
                mbe_pkg::CFG_WIDTH:  cfg_next.width  = clamped_dim;
                mbe_pkg::CFG_BORDER: cfg_next.border = cfg_data[mbe_pkg::BORDER_W-1:0];
                mbe_pkg::CFG_MODE:   cfg_next.mode   = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // fetch classification
    always_comb
    begin
        row_limit = {1'b0, cfg_reg.height} + {4'b0000, cfg_reg.border, 1'b0};
        col_limit = {1'b0, cfg_reg.width} + {4'b0000, cfg_reg.border, 1'b0};
        out_of_range = ({1'b0, request.row} >= row_limit) ||
                       ({1'b0, request.col} >= col_limit);
        if (cfg_reg.mode)
            too_wide = ({4'b0000, cfg_reg.border} > cfg_reg.height) ||
                       ({4'b0000, cfg_reg.border} > cfg_reg.width);
        else
            too_wide = ({4'b0000, cfg_reg.border} >= cfg_reg.height) ||
                       ({4'b0000, cfg_reg.border} >= cfg_reg.width);
        fetch_row_idx = mirror_index(request.row, cfg_reg.border, cfg_reg.height,
                                     cfg_reg.mode);
        fetch_col_idx = mirror_index(request.col, cfg_reg.border, cfg_reg.width,
                                     cfg_reg.mode);
    end

    always_comb
    begin
        load_pos_next       = load_pos_reg;
        load_col_next       = load_col_reg;
        load_row_next       = load_row_reg;
        frame_complete_next = frame_complete_reg;
        front_valid_next    = front_valid_reg && cmd_full;
        front_item_next     = front_item_reg;

        if (accept)
        begin
            front_valid_next          = 1'b1;
            front_item_next.is_fetch  = (request.operation == mbe_pkg::OP_FETCH);
            front_item_next.pixel     = request.pixel[mbe_pkg::PIXEL_BITS-1:0];
            front_item_next.load_addr = load_pos_reg;
            front_item_next.r         = fetch_row_idx[mbe_pkg::ROW_W-1:0];
            front_item_next.c         = fetch_col_idx[mbe_pkg::COL_W-1:0];
            if (out_of_range)
                front_item_next.status = mbe_pkg::ST_RANGE;
            else if (too_wide)
                front_item_next.status = mbe_pkg::ST_BORDER;
            else if (!frame_complete_reg)
                front_item_next.status = mbe_pkg::ST_INCOMPLETE;
            else
                front_item_next.status = mbe_pkg::ST_OK;

            if (request.operation == mbe_pkg::OP_LOAD)
            begin
                if ({1'b0, load_col_reg} == cfg_reg.width - 1'b1)
                begin
                    load_col_next = '0;
                    if ({1'b0, load_row_reg} == cfg_reg.height - 1'b1)
                    begin
                        load_row_next       = '0;
                        load_pos_next       = '0;
                        frame_complete_next = 1'b1;
                    end
                    else
                    begin
                        load_row_next = load_row_reg + 1'b1;
                        load_pos_next = load_pos_reg + 1'b1;
                    end
                end
                else
                begin
                    load_col_next = load_col_reg + 1'b1;
                    load_pos_next = load_pos_reg + 1'b1;
                end
            end
        end

        if (geom_write)
        begin
            load_pos_next       = '0;
            load_col_next       = '0;
            load_row_next       = '0;
            frame_complete_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height     <= mbe_pkg::DIM_W'(mbe_pkg::MAX_HEIGHT);
            cfg_reg.width      <= mbe_pkg::DIM_W'(mbe_pkg::MAX_WIDTH);
            cfg_reg.border     <= mbe_pkg::BORDER_W'(1);
            cfg_reg.mode       <= 1'b0;
            load_pos_reg       <= '0;
            load_col_reg       <= '0;
            load_row_reg       <= '0;
            frame_complete_reg <= 1'b0;
            front_valid_reg    <= 1'b0;
        end
        else
        begin
            cfg_reg            <= cfg_next;
            load_pos_reg       <= load_pos_next;
            load_col_reg       <= load_col_next;
            load_row_reg       <= load_row_next;
            frame_complete_reg <= frame_complete_next;
            front_valid_reg    <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_item_reg <= front_item_next;
    end

    a_geom_restarts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        geom_write |=> !frame_complete_reg && load_pos_reg == '0)
        else $error("geometry write did not restart the frame");

endmodule

`default_nettype wire

// File: src/mbe_cmd_queue.sv
`default_nettype none

module mbe_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire mbe_pkg::cmd_t  wr_item,
    output logic                full,
    input  wire logic           rd_en,
    output mbe_pkg::cmd_t       rd_item,
    output logic                valid
);

    mbe_pkg::cmd_t                 entries [mbe_pkg::CMD_DEPTH];
    logic [mbe_pkg::CMD_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mbe_pkg::CMD_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mbe_pkg::CMD_CW-1:0]    count_reg, count_next;

    assign full    = count_reg == mbe_pkg::CMD_CW'(mbe_pkg::CMD_DEPTH);
    assign valid   = count_reg != '0;
    assign rd_item = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !full)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (rd_en && valid)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if ((wr_en && !full) && !(rd_en && valid))
            count_next = count_reg + 1'b1;
        else if (!(wr_en && !full) && (rd_en && valid))
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            entries[wr_ptr_reg] <= wr_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mbe_pkg::CMD_CW'(mbe_pkg::CMD_DEPTH))
        else $error("command queue count overflow");

endmodule

`default_nettype wire

// File: src/mbe_back.sv
`default_nettype none

module mbe_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mbe_pkg::cfg_t  cfg,
    input  wire logic           cmd_valid,
    input  wire mbe_pkg::cmd_t  cmd_item,
    output logic                cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output mbe_pkg::out_item_t  result
);

    logic [mbe_pkg::PIXEL_BITS-1:0] frame_store [mbe_pkg::STORE_DEPTH];

    logic                           s1_valid_reg;
    logic                           s1_fetch_reg;
    logic [mbe_pkg::ADDR_W-1:0]     s1_addr_reg;
    logic [mbe_pkg::PIXEL_BITS-1:0] s1_pixel_reg;
    mbe_pkg::status_t               s1_status_reg;
    logic [mbe_pkg::ADDR_W:0]       fetch_addr;

    logic                           s2_valid_reg;
    mbe_pkg::status_t               s2_status_reg;
    logic [mbe_pkg::PIXEL_BITS-1:0] rd_data_reg;

    mbe_pkg::out_item_t             out_entries [mbe_pkg::OUT_DEPTH];
    mbe_pkg::out_item_t             out_push_item;
    logic [mbe_pkg::OUT_AW-1:0]     out_wr_ptr_reg;
    logic [mbe_pkg::OUT_AW-1:0]     out_rd_ptr_reg;
    logic [mbe_pkg::OUT_CW-1:0]     out_count_reg, out_count_next;
    logic [mbe_pkg::OUT_CW:0]       committed;
    logic                           out_pop;

    // results already promised must fit in the result queue
    assign committed = {1'b0, out_count_reg}
                     + (mbe_pkg::OUT_CW + 1)'(s1_valid_reg && s1_fetch_reg)
                     + (mbe_pkg::OUT_CW + 1)'(s2_valid_reg);
    assign cmd_pop   = cmd_valid && (committed < (mbe_pkg::OUT_CW + 1)'(mbe_pkg::OUT_DEPTH));

    assign fetch_addr = (mbe_pkg::ADDR_W + 1)'(cmd_item.r) * (mbe_pkg::ADDR_W + 1)'(cfg.width)
                      + (mbe_pkg::ADDR_W + 1)'(cmd_item.c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_pop;
            s2_valid_reg <= s1_valid_reg && s1_fetch_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fetch_reg  <= cmd_item.is_fetch;
        s1_addr_reg   <= cmd_item.is_fetch ? fetch_addr[mbe_pkg::ADDR_W-1:0]
                                           : cmd_item.load_addr;
        s1_pixel_reg  <= cmd_item.pixel;
        s1_status_reg <= cmd_item.status;
        s2_status_reg <= s1_status_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !s1_fetch_reg)
            frame_store[s1_addr_reg] <= s1_pixel_reg;
        rd_data_reg <= frame_store[s1_addr_reg];
    end

    // result queue
    assign empty   = out_count_reg == '0;
    assign out_pop = pop && !empty;
    assign result  = out_entries[out_rd_ptr_reg];

    always_comb
    begin
        out_push_item.status       = s2_status_reg;
        out_push_item.padded_pixel = (s2_status_reg == mbe_pkg::ST_OK) ?
                                     24'(rd_data_reg) : 24'd0;
        out_count_next = out_count_reg;
        if (s2_valid_reg && !out_pop)
            out_count_next = out_count_reg + 1'b1;
        else if (!s2_valid_reg && out_pop)
            out_count_next = out_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (s2_valid_reg)
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            if (out_pop)
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            out_entries[out_wr_ptr_reg] <= out_push_item;
    end

    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (out_count_reg < mbe_pkg::OUT_CW'(mbe_pkg::OUT_DEPTH)) || out_pop)
        else $error("result queue overflow");

    a_error_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status != mbe_pkg::ST_OK |-> result.padded_pixel == '0)
        else $error("error result carries a pixel");

endmodule

`default_nettype wire

// File: src/mirror_border_extension.sv
// Path: a fetch result reaches the result ports through the front register, command queue
//   write, address multiply, frame store read and result queue write.
// Throughput: one load or fetch per cycle while results are popped; with pop held low the
//   input stalls after nine fetches (four on the result side, four queued, one in front).
// Reset: asynchronous, active low; 128 x 128 image, border 1, mode 0, frame incomplete.
//   The frame store itself is not cleared.
`default_nettype none

module mirror_border_extension (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire mbe_pkg::in_item_t              request,
    output logic                                full,
    output logic                                empty,
    input  wire logic                           pop,
    output mbe_pkg::out_item_t                  result,
    input  wire logic                           cfg_we,
    input  wire mbe_pkg::cfg_index_t            cfg_index,
    input  wire logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data
);

    mbe_pkg::cfg_t cfg;
    logic          front_valid;
    mbe_pkg::cmd_t front_item;
    logic          cmd_full;
    logic          cmd_valid;
    mbe_pkg::cmd_t cmd_item;
    logic          cmd_pop;

    mbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cmd_valid (front_valid),
        .cmd_item  (front_item),
        .cmd_full  (cmd_full)
    );

    mbe_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_item (front_item),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_item (cmd_item),
        .valid   (cmd_valid)
    );

    mbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_item  (cmd_item),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
